>>> rtl/suv_pkg.sv
// ----------------------------------------------------------------------------
// suv_pkg
// Shared types, widths and constants of the spherical uv mapping pipeline.
// ----------------------------------------------------------------------------
package suv_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int FRAC_BITS         = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // coordinates are placed high in a 64-bit word so the chains keep precision
    localparam int PRESCALE = 60 - COORD_WIDTH;
    localparam int DATA_W   = 64;
    localparam int ANG_W    = 34;
    localparam int TURN_W   = 32;
    localparam int RSHIFT   = TURN_W - FRAC_BITS;
    localparam int MODE_W   = 2;

    localparam int U_W  = 17;
    localparam int V_W  = 18;
    localparam int UM_W = TURN_W + 1;
    localparam int VM_W = TURN_W + 2;

    localparam int GAIN_W = 30;
    localparam int PROD_W = TURN_W + GAIN_W;

    // 1/K of the chain, 30 fraction bits, truncated
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [TURN_W:0]   FULL_TURN = 33'h1_0000_0000;
    localparam logic signed [ANG_W-1:0] HALF_ANG =
        $signed({{(ANG_W-TURN_W){1'b0}}, HALF_TURN});

    localparam logic [U_W-1:0] U_MAX = U_W'(3 << (FRAC_BITS - 1));
    localparam logic [V_W-1:0] V_MAX = V_W'(3 << FRAC_BITS);

    typedef enum logic [MODE_W-1:0] {
        MODE_PLAIN     = 2'd0,
        MODE_FOLD      = 2'd1,
        MODE_TILE      = 2'd2,
        MODE_PLAIN_ALT = 2'd3
    } map_mode_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic                          last_vertex;
    } suv_in_t;

    typedef struct packed {
        logic [U_W-1:0] tex_u;
        logic [V_W-1:0] tex_v;
        logic           last_out;
    } suv_out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ANG_W-1:0]  ang;
    } cordic_t;

    // carried alongside the azimuth chain
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic                          axis_y;
        logic                          zero_vec;
        logic                          flip;
        logic                          last;
    } side1_t;

    // carried alongside the polar chain
    typedef struct packed {
        logic [TURN_W-1:0] u_turn;
        logic              zero_vec;
        logic              flip;
        logic              last;
    } side2_t;

    localparam int SIDE1_W = $bits(side1_t);
    localparam int SIDE2_W = $bits(side2_t);

    // arctan(2^-i) in binary angle units, full turn = 2^32
    function automatic logic [TURN_W-1:0] atan_entry(input int idx);
        logic [TURN_W-1:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/spherical_uv_mapping.sv
// ----------------------------------------------------------------------------
// spherical_uv_mapping
// Maps a vertex position to spherical texture coordinates (u, v). The block
// takes one vertex per clock while not stalled and returns one result per
// vertex, in order. The pipe is one setup stage, the azimuth CORDIC chain
// with one iteration per stage, two stages for the magnitude gain multiply,
// the polar CORDIC chain, and three stages for clamping, map mode and
// rounding. Every stage holds its item under stall and empty stages fill up,
// so a stalled output only blocks the input once the pipeline is full.
// map_mode is sampled late in the pipe; write it only while no vertex is in
// flight.
// ----------------------------------------------------------------------------
module spherical_uv_mapping
#(
    parameter int CORDIC_STAGES = suv_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [suv_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  suv_pkg::suv_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output suv_pkg::suv_out_t           out_data
);
    import suv_pkg::*;

    map_mode_t                map_mode_reg;

    // setup stage
    logic                     p_valid_reg;
    logic                     p_stall;
    cordic_t                  p_vec_reg;
    side1_t                   p_side_reg;
    cordic_t                  p_vec_next;
    side1_t                   p_side_next;
    logic signed [DATA_W-1:0] x_scaled;
    logic signed [DATA_W-1:0] z_scaled;

    // azimuth chain
    logic                     c1_stall_in;
    logic                     c1_valid;
    logic                     c1_stall;
    cordic_t                  c1_vec;
    logic [SIDE1_W-1:0]       c1_side;

    // polar chain
    logic                     g_valid;
    logic                     g_stall;
    cordic_t                  g_vec;
    side2_t                   g_side;
    logic                     c2_valid;
    logic                     c2_stall;
    cordic_t                  c2_vec;
    logic [SIDE2_W-1:0]       c2_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg <= MODE_PLAIN;
        end
        else if (cfg_wr_en)
        begin
            map_mode_reg <= map_mode_t'(cfg_wr_data);
        end
    end

    always_comb
    begin
        x_scaled = $signed({{(DATA_W-COORD_WIDTH){in_data.pos_x[COORD_WIDTH-1]}},
                            in_data.pos_x}) <<< PRESCALE;
        z_scaled = $signed({{(DATA_W-COORD_WIDTH){in_data.pos_z[COORD_WIDTH-1]}},
                            in_data.pos_z}) <<< PRESCALE;
        p_vec_next.ang       = '0;
        p_side_next.pos_y    = in_data.pos_y;
        p_side_next.axis_y   = (in_data.pos_x == '0) && (in_data.pos_z == '0);
        p_side_next.zero_vec = p_side_next.axis_y && (in_data.pos_y == '0);
        p_side_next.last     = in_data.last_vertex;
        // rotate by half a turn so the chain starts in the right half plane
        if (in_data.pos_z < 0)
        begin
            p_vec_next.x     = -z_scaled;
            p_vec_next.y     = -x_scaled;
            p_side_next.flip = 1'b1;
        end
        else
        begin
            p_vec_next.x     = z_scaled;
            p_vec_next.y     = x_scaled;
            p_side_next.flip = 1'b0;
        end
    end

    assign p_stall  = p_valid_reg && c1_stall_in;
    assign in_stall = p_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (!p_stall)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!p_stall && in_valid)
        begin
            p_vec_reg  <= p_vec_next;
            p_side_reg <= p_side_next;
        end
    end

    suv_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (SIDE1_W)
    ) u_cordic_azim (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_stall  (c1_stall_in),
        .in_vec    (p_vec_reg),
        .in_side   (p_side_reg),
        .out_valid (c1_valid),
        .out_stall (c1_stall),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    suv_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_stall  (c1_stall),
        .in_vec    (c1_vec),
        .in_side   (side1_t'(c1_side)),
        .out_valid (g_valid),
        .out_stall (g_stall),
        .out_vec   (g_vec),
        .out_side  (g_side)
    );

    suv_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (SIDE2_W)
    ) u_cordic_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_stall  (g_stall),
        .in_vec    (g_vec),
        .in_side   (g_side),
        .out_valid (c2_valid),
        .out_stall (c2_stall),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    suv_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_mode  (map_mode_reg),
        .in_valid  (c2_valid),
        .in_stall  (c2_stall),
        .in_vec    (c2_vec),
        .in_side   (side2_t'(c2_side)),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a transaction held at the end of a chain must not drop, nor its sideband change
    a_azim_hold: assert property (@(posedge clk) disable iff (!rst_n)
        c1_valid && c1_stall |=> c1_valid && $stable(c1_side))
        else $error("azimuth chain lost a held transaction");

    a_polar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid && c2_stall |=> c2_valid && $stable(c2_side))
        else $error("polar chain lost a held transaction");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tex_u <= U_MAX) && (out_data.tex_v <= V_MAX))
        else $error("texture coordinate out of range");

endmodule

>>> rtl/suv_cordic_stage.sv
// ----------------------------------------------------------------------------
// suv_cordic_stage
// One registered vectoring iteration with a pass-through sideband word.
// ----------------------------------------------------------------------------
module suv_cordic_stage
#(
    parameter int SHIFT = 0,
    parameter int SB_W  = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  suv_pkg::cordic_t    in_vec,
    input  logic [SB_W-1:0]     in_side,
    output logic                out_valid,
    input  logic                out_stall,
    output suv_pkg::cordic_t    out_vec,
    output logic [SB_W-1:0]     out_side
);
    import suv_pkg::*;

    logic                     valid_reg;
    cordic_t                  vec_reg;
    cordic_t                  vec_next;
    logic [SB_W-1:0]          side_reg;
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] y_in;
    logic signed [ANG_W-1:0]  ang_in;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [ANG_W-1:0]  da;

    always_comb
    begin
        x_in   = in_vec.x;
        y_in   = in_vec.y;
        ang_in = in_vec.ang;
        // arithmetic shift rounds toward minus infinity
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        da = $signed({{(ANG_W-TURN_W){1'b0}}, atan_entry(SHIFT)});
        if (y_in > 0)
        begin
            vec_next.x   = x_in + dx;
            vec_next.y   = y_in - dy;
            vec_next.ang = ang_in + da;
        end
        else
        begin
            vec_next.x   = x_in - dx;
            vec_next.y   = y_in + dy;
            vec_next.ang = ang_in - da;
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/suv_cordic.sv
// ----------------------------------------------------------------------------
// suv_cordic
// Pipelined vectoring chain, one iteration per register stage.
// ----------------------------------------------------------------------------
module suv_cordic
#(
    parameter int STAGES = suv_pkg::CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  suv_pkg::cordic_t    in_vec,
    input  logic [SB_W-1:0]     in_side,
    output logic                out_valid,
    input  logic                out_stall,
    output suv_pkg::cordic_t    out_vec,
    output logic [SB_W-1:0]     out_side
);
    import suv_pkg::*;

    logic            valid_w [STAGES+1];
    logic            stall_w [STAGES+1];
    cordic_t         vec_w   [STAGES+1];
    logic [SB_W-1:0] side_w  [STAGES+1];

    assign valid_w[0]      = in_valid;
    assign vec_w[0]        = in_vec;
    assign side_w[0]       = in_side;
    assign in_stall        = stall_w[0];
    assign stall_w[STAGES] = out_stall;
    assign out_valid       = valid_w[STAGES];
    assign out_vec         = vec_w[STAGES];
    assign out_side        = side_w[STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        suv_cordic_stage #(
            .SHIFT (i),
            .SB_W  (SB_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_stall  (stall_w[i]),
            .in_vec    (vec_w[i]),
            .in_side   (side_w[i]),
            .out_valid (valid_w[i+1]),
            .out_stall (stall_w[i+1]),
            .out_vec   (vec_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

endmodule

>>> rtl/suv_gain.sv
// ----------------------------------------------------------------------------
// suv_gain
// Azimuth to u, magnitude gain correction and setup of the polar chain.
// ----------------------------------------------------------------------------
module suv_gain
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  suv_pkg::cordic_t    in_vec,
    input  suv_pkg::side1_t     in_side,
    output logic                out_valid,
    input  logic                out_stall,
    output suv_pkg::cordic_t    out_vec,
    output suv_pkg::side2_t     out_side
);
    import suv_pkg::*;

    // stage a: partial products and u
    logic                          a_valid_reg;
    logic                          a_stall;
    logic [PROD_W-1:0]             a_prod_hi_reg;
    logic [PROD_W-1:0]             a_prod_lo_reg;
    logic [TURN_W-1:0]             a_u_reg;
    logic signed [COORD_WIDTH-1:0] a_pos_y_reg;
    logic                          a_axis_reg;
    logic                          a_zero_reg;
    logic                          a_last_reg;

    logic [DATA_W-1:0]             mag;
    logic [PROD_W-1:0]             prod_hi_next;
    logic [PROD_W-1:0]             prod_lo_next;
    logic signed [ANG_W-1:0]       phi;
    logic [TURN_W-1:0]             u_raw;
    logic [TURN_W-1:0]             u_next;

    // stage b: magnitude and polar chain setup
    logic                          b_valid_reg;
    logic                          b_stall;
    cordic_t                       b_vec_reg;
    side2_t                        b_side_reg;
    cordic_t                       b_vec_next;
    side2_t                        b_side_next;
    logic [PROD_W-GAIN_W-1:0]      lo_part;
    logic [DATA_W-1:0]             r_sum;
    logic signed [DATA_W-1:0]      r_mag;
    logic signed [DATA_W-1:0]      y_scaled;

    always_comb
    begin
        mag          = in_vec.x;
        prod_hi_next = PROD_W'(mag[DATA_W-1:TURN_W]) * PROD_W'(INV_GAIN);
        prod_lo_next = PROD_W'(mag[TURN_W-1:0]) * PROD_W'(INV_GAIN);
        if (in_side.axis_y)
        begin
            phi = '0;
        end
        else if (in_side.flip)
        begin
            phi = in_vec.ang + HALF_ANG;
        end
        else
        begin
            phi = in_vec.ang;
        end
        u_raw = phi[TURN_W-1:0] + HALF_TURN;
        // fold to min(u, 1-u)
        if (u_raw > HALF_TURN)
        begin
            u_next = '0 - u_raw;
        end
        else
        begin
            u_next = u_raw;
        end
    end

    always_comb
    begin
        lo_part  = a_prod_lo_reg[PROD_W-1:GAIN_W];
        r_sum    = {a_prod_hi_reg, 2'b00} + DATA_W'(lo_part);
        r_mag    = a_axis_reg ? '0 : $signed(r_sum);
        y_scaled = $signed({{(DATA_W-COORD_WIDTH){a_pos_y_reg[COORD_WIDTH-1]}}, a_pos_y_reg})
                   <<< PRESCALE;
        b_vec_next.ang       = '0;
        b_side_next.u_turn   = a_u_reg;
        b_side_next.zero_vec = a_zero_reg;
        b_side_next.last     = a_last_reg;
        if (a_pos_y_reg < 0)
        begin
            b_vec_next.x     = -y_scaled;
            b_vec_next.y     = -r_mag;
            b_side_next.flip = 1'b1;
        end
        else
        begin
            b_vec_next.x     = y_scaled;
            b_vec_next.y     = r_mag;
            b_side_next.flip = 1'b0;
        end
    end

    assign b_stall  = b_valid_reg && out_stall;
    assign a_stall  = a_valid_reg && b_stall;
    assign in_stall = a_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (!a_stall)
            begin
                a_valid_reg <= in_valid;
            end
            if (!b_stall)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!a_stall && in_valid)
        begin
            a_prod_hi_reg <= prod_hi_next;
            a_prod_lo_reg <= prod_lo_next;
            a_u_reg       <= u_next;
            a_pos_y_reg   <= in_side.pos_y;
            a_axis_reg    <= in_side.axis_y;
            a_zero_reg    <= in_side.zero_vec;
            a_last_reg    <= in_side.last;
        end
        if (!b_stall && a_valid_reg)
        begin
            b_vec_reg  <= b_vec_next;
            b_side_reg <= b_side_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = b_vec_reg;
    assign out_side  = b_side_reg;

endmodule

>>> rtl/suv_out.sv
// ----------------------------------------------------------------------------
// suv_out
// Polar angle to v, map mode fold or tiling, rounding and output register.
// ----------------------------------------------------------------------------
module suv_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  suv_pkg::map_mode_t  map_mode,
    input  logic                in_valid,
    output logic                in_stall,
    input  suv_pkg::cordic_t    in_vec,
    input  suv_pkg::side2_t     in_side,
    output logic                out_valid,
    input  logic                out_stall,
    output suv_pkg::suv_out_t   out_data
);
    import suv_pkg::*;

    localparam logic [UM_W:0] ROUND_U      = (UM_W+1)'(1) << (RSHIFT - 1);
    localparam logic [UM_W:0] ROUND_U_HALF = (UM_W+1)'(1) << RSHIFT;
    localparam logic [VM_W:0] ROUND_V      = (VM_W+1)'(1) << (RSHIFT - 1);

    // stage 1: clamped angles
    logic                    s1_valid_reg;
    logic                    s1_stall;
    logic [TURN_W-1:0]       s1_u_reg;
    logic [TURN_W:0]         s1_v_reg;
    logic                    s1_last_reg;
    logic signed [ANG_W-1:0] theta;
    logic [TURN_W-1:0]       theta_c;
    logic [TURN_W-1:0]       s1_u_next;
    logic [TURN_W:0]         s1_v_next;

    // stage 2: mode applied
    logic                    s2_valid_reg;
    logic                    s2_stall;
    logic [UM_W-1:0]         s2_u_reg;
    logic [VM_W-1:0]         s2_v_reg;
    logic                    s2_half_reg;
    logic                    s2_last_reg;
    logic [UM_W-1:0]         s2_u_next;
    logic [VM_W-1:0]         s2_v_next;
    logic                    s2_half_next;
    logic [TURN_W:0]         v_fold;

    // output stage
    logic                    out_valid_reg;
    logic                    o_stall;
    suv_out_t                out_data_reg;
    suv_out_t                out_data_next;
    logic [UM_W:0]           u_sum;
    logic [UM_W:0]           u_shift;
    logic [VM_W:0]           v_sum;
    logic [VM_W:0]           v_shift;

    always_comb
    begin
        if (in_side.flip)
        begin
            theta = in_vec.ang + HALF_ANG;
        end
        else
        begin
            theta = in_vec.ang;
        end
        // keep residual chain error inside [0, pi]
        if (theta < 0)
        begin
            theta_c = '0;
        end
        else if (theta > HALF_ANG)
        begin
            theta_c = HALF_TURN;
        end
        else
        begin
            theta_c = theta[TURN_W-1:0];
        end
        if (in_side.zero_vec)
        begin
            s1_u_next = HALF_TURN;
            s1_v_next = {1'b0, HALF_TURN};
        end
        else
        begin
            s1_u_next = in_side.u_turn;
            s1_v_next = {theta_c, 1'b0};
        end
    end

    always_comb
    begin
        v_fold = (s1_v_reg > {1'b0, HALF_TURN}) ? FULL_TURN - s1_v_reg : s1_v_reg;
        case (map_mode)
            MODE_FOLD:
            begin
                s2_u_next    = UM_W'(s1_u_reg);
                s2_v_next    = VM_W'(v_fold);
                s2_half_next = 1'b1;
            end
            MODE_TILE:
            begin
                s2_u_next    = {1'b0, s1_u_reg} + {s1_u_reg, 1'b0};
                s2_v_next    = {1'b0, s1_v_reg} + {s1_v_reg, 1'b0};
                s2_half_next = 1'b0;
            end
            default:
            begin
                s2_u_next    = UM_W'(s1_u_reg);
                s2_v_next    = VM_W'(s1_v_reg);
                s2_half_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        // halving in fold mode rides on the rounding shift
        if (s2_half_reg)
        begin
            u_sum   = {1'b0, s2_u_reg} + ROUND_U_HALF;
            u_shift = u_sum >> (RSHIFT + 1);
        end
        else
        begin
            u_sum   = {1'b0, s2_u_reg} + ROUND_U;
            u_shift = u_sum >> RSHIFT;
        end
        v_sum   = {1'b0, s2_v_reg} + ROUND_V;
        v_shift = v_sum >> RSHIFT;
        out_data_next.tex_u    = u_shift[U_W-1:0];
        out_data_next.tex_v    = v_shift[V_W-1:0];
        out_data_next.last_out = s2_last_reg;
    end

    assign o_stall  = out_valid_reg && out_stall;
    assign s2_stall = s2_valid_reg && o_stall;
    assign s1_stall = s1_valid_reg && s2_stall;
    assign in_stall = s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_stall)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!o_stall)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && in_valid)
        begin
            s1_u_reg    <= s1_u_next;
            s1_v_reg    <= s1_v_next;
            s1_last_reg <= in_side.last;
        end
        if (!s2_stall && s1_valid_reg)
        begin
            s2_u_reg    <= s2_u_next;
            s2_v_reg    <= s2_v_next;
            s2_half_reg <= s2_half_next;
            s2_last_reg <= s1_last_reg;
        end
        if (!o_stall && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
